// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell and sorted_priority_queue.
`default_nettype none

package spq_pkg;

    // Fixed widths of the item fields at the ports
    localparam int unsigned FIELD_BITS = 32;
    localparam int unsigned COUNT_BITS = 5;

    // Operation codes carried in the operation field
    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } spq_op_t;

    // Command broadcast to every cell in a cycle
    typedef struct packed {
        logic push;
        logic pop;
    } spq_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/spq_cell.sv
// One slot of the sorted queue: key, payload and valid flag.
// Shifts up on an insert below it and down on a pop; uses spq_pkg.
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int unsigned KEY_BITS     = 32,
    parameter int unsigned PAYLOAD_BITS = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire spq_ctrl_t               ctrl,
    input  wire logic [KEY_BITS-1:0]     new_key,
    input  wire logic [PAYLOAD_BITS-1:0] new_payload,
    input  wire logic                    left_ge,
    input  wire logic                    left_valid,
    input  wire logic [KEY_BITS-1:0]     left_key,
    input  wire logic [PAYLOAD_BITS-1:0] left_payload,
    input  wire logic                    right_valid,
    input  wire logic [KEY_BITS-1:0]     right_key,
    input  wire logic [PAYLOAD_BITS-1:0] right_payload,
    output logic                         ge,
    output logic                         valid,
    output logic [KEY_BITS-1:0]          slot_key,
    output logic [PAYLOAD_BITS-1:0]      slot_payload
);

    logic                    valid_reg;
    logic                    valid_next;
    logic [KEY_BITS-1:0]     key_reg;
    logic [KEY_BITS-1:0]     key_next;
    logic [PAYLOAD_BITS-1:0] payload_reg;
    logic [PAYLOAD_BITS-1:0] payload_next;
    logic                    load;

    // New entry belongs at or below this slot: slot empty or new key not larger
    assign ge = !valid_reg || (new_key <= key_reg);

    // Pick the next contents: take the new entry, shift up from the left,
    // shift down from the right, or hold
    always_comb
    begin
        valid_next   = valid_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        load         = 1'b0;
        if (ctrl.push && ge)
        begin
            load = 1'b1;
            if (left_ge)
            begin
                valid_next   = left_valid;
                key_next     = left_key;
                payload_next = left_payload;
            end
            else
            begin
                valid_next   = 1'b1;
                key_next     = new_key;
                payload_next = new_payload;
            end
        end
        else if (ctrl.pop)
        begin
            load         = 1'b1;
            valid_next   = right_valid;
            key_next     = right_key;
            payload_next = right_payload;
        end
    end

    // Valid flag under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slot contents, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg     <= key_next;
            payload_reg <= payload_next;
        end
    end

    assign valid        = valid_reg;
    assign slot_key     = key_reg;
    assign slot_payload = payload_reg;

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Sorted priority queue top level: a chain of spq_cell slots plus the
// count and result register; uses spq_pkg and spq_cell.
//
// Bounded priority queue of DEPTH entries held in ascending key order in a
// row of slot cells. Each accepted item is a push (operation OP_PUSH) or a
// pop (OP_POP); every item gives exactly one result in the next cycle. A push
// is inserted in front of the first entry whose key is not smaller, so among
// equal keys the newest leaves first; a push to a full queue is discarded
// and reported in push_dropped. A pop returns the smallest entry, or
// pop_valid low with zero key and payload when empty. entry_count is the
// count after the operation, modulo 32. The queue takes one item per clock:
// all cells compare the incoming key against their own key in parallel and
// shift by one place in the same cycle, so the rate is set by that single
// compare-and-shift step. The result sits in an output register; a new item
// is accepted whenever that register is empty or is being taken, and
// in_stall rises only while a result is held under out_stall.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH        = 16,
    parameter int unsigned KEY_BITS     = 32,
    parameter int unsigned PAYLOAD_BITS = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  operation,
    input  wire logic [FIELD_BITS-1:0] key,
    input  wire logic [FIELD_BITS-1:0] payload,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       pop_valid,
    output logic [FIELD_BITS-1:0]      pop_key,
    output logic [FIELD_BITS-1:0]      pop_payload,
    output logic                       push_dropped,
    output logic [COUNT_BITS-1:0]      entry_count
);

    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
    localparam int unsigned KEY_COPY = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int unsigned PAY_COPY =
        (PAYLOAD_BITS < FIELD_BITS) ? PAYLOAD_BITS : FIELD_BITS;
    localparam int unsigned CNT_COPY = (CNT_BITS < COUNT_BITS) ? CNT_BITS : COUNT_BITS;

    logic                    accept;
    logic                    full;
    logic                    empty;
    spq_ctrl_t               ctrl;
    logic [KEY_BITS-1:0]     in_key;
    logic [PAYLOAD_BITS-1:0] in_payload;

    logic                    cell_ge      [DEPTH];
    logic                    cell_valid   [DEPTH];
    logic [KEY_BITS-1:0]     cell_key     [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];

    logic [CNT_BITS-1:0]     count_reg;
    logic [CNT_BITS-1:0]     count_next;

    logic                    out_valid_reg;
    logic                    pop_valid_reg;
    logic                    pop_valid_next;
    logic [FIELD_BITS-1:0]   pop_key_reg;
    logic [FIELD_BITS-1:0]   pop_key_next;
    logic [FIELD_BITS-1:0]   pop_payload_reg;
    logic [FIELD_BITS-1:0]   pop_payload_next;
    logic                    push_dropped_reg;
    logic                    push_dropped_next;
    logic [COUNT_BITS-1:0]   entry_count_reg;
    logic [COUNT_BITS-1:0]   entry_count_next;

    // Take an item unless a held result is stalled
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full  = cell_valid[DEPTH-1];
    assign empty = !cell_valid[0];

    // Fit the port fields to the stored widths
    always_comb
    begin
        in_key                       = '0;
        in_key[KEY_COPY-1:0]         = key[KEY_COPY-1:0];
        in_payload                   = '0;
        in_payload[PAY_COPY-1:0]     = payload[PAY_COPY-1:0];
    end

    // Command to the cells: drop pushes to a full queue, pops on empty
    always_comb
    begin
        ctrl.push = accept && (spq_op_t'(operation) == OP_PUSH) && !full;
        ctrl.pop  = accept && (spq_op_t'(operation) == OP_POP) && !empty;
    end

    // Row of slot cells, smallest key in slot 0
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                    l_ge;
        logic                    l_valid;
        logic [KEY_BITS-1:0]     l_key;
        logic [PAYLOAD_BITS-1:0] l_payload;
        logic                    r_valid;
        logic [KEY_BITS-1:0]     r_key;
        logic [PAYLOAD_BITS-1:0] r_payload;

        if (i == 0)
        begin : g_head
            assign l_ge      = 1'b0;
            assign l_valid   = 1'b0;
            assign l_key     = '0;
            assign l_payload = '0;
        end
        else
        begin : g_body
            assign l_ge      = cell_ge[i-1];
            assign l_valid   = cell_valid[i-1];
            assign l_key     = cell_key[i-1];
            assign l_payload = cell_payload[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_valid   = 1'b0;
            assign r_key     = '0;
            assign r_payload = '0;
        end
        else
        begin : g_inner
            assign r_valid   = cell_valid[i+1];
            assign r_key     = cell_key[i+1];
            assign r_payload = cell_payload[i+1];
        end

        spq_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .new_key       (in_key),
            .new_payload   (in_payload),
            .left_ge       (l_ge),
            .left_valid    (l_valid),
            .left_key      (l_key),
            .left_payload  (l_payload),
            .right_valid   (r_valid),
            .right_key     (r_key),
            .right_payload (r_payload),
            .ge            (cell_ge[i]),
            .valid         (cell_valid[i]),
            .slot_key      (cell_key[i]),
            .slot_payload  (cell_payload[i])
        );
    end

    // Advance the entry count and build the result
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end

        pop_valid_next    = ctrl.pop;
        pop_key_next      = '0;
        pop_payload_next  = '0;
        if (ctrl.pop)
        begin
            pop_key_next[KEY_COPY-1:0]     = cell_key[0][KEY_COPY-1:0];
            pop_payload_next[PAY_COPY-1:0] = cell_payload[0][PAY_COPY-1:0];
        end
        push_dropped_next = accept && (spq_op_t'(operation) == OP_PUSH) && full;
        entry_count_next                 = '0;
        entry_count_next[CNT_COPY-1:0]   = count_next[CNT_COPY-1:0];
    end

    // Count and result valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded when an item is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_valid_reg    <= pop_valid_next;
            pop_key_reg      <= pop_key_next;
            pop_payload_reg  <= pop_payload_next;
            push_dropped_reg <= push_dropped_next;
            entry_count_reg  <= entry_count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pop_valid    = pop_valid_reg;
    assign pop_key      = pop_key_reg;
    assign pop_payload  = pop_payload_reg;
    assign push_dropped = push_dropped_reg;
    assign entry_count  = entry_count_reg;

endmodule

`default_nettype wire

// File: tb/sorted_priority_queue_test.sv
// Self-checking testbench for sorted_priority_queue: directed rows, then random push/pop items.
// Depends on spq_pkg and the sorted_priority_queue RTL; keeps a shadow sorted list as predictor.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned KEY_BITS     = 32;
    localparam int unsigned PAYLOAD_BITS = 32;
    localparam int unsigned PHASES       = 35;
    localparam int unsigned PHASE_ITEMS  = 50;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned ROWS         = 10;

    localparam logic [FIELD_BITS-1:0] KEY_MASK =
        (KEY_BITS >= FIELD_BITS) ? '1 : FIELD_BITS'((64'd1 << KEY_BITS) - 1);
    localparam logic [FIELD_BITS-1:0] PAYLOAD_MASK =
        (PAYLOAD_BITS >= FIELD_BITS) ? '1 : FIELD_BITS'((64'd1 << PAYLOAD_BITS) - 1);

    typedef struct packed {
        logic                  pop_valid;
        logic [FIELD_BITS-1:0] pop_key;
        logic [FIELD_BITS-1:0] pop_payload;
        logic                  push_dropped;
        logic [COUNT_BITS-1:0] entry_count;
    } queue_result_t;

    typedef struct {
        spq_op_t               op;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] payload;
        int                    reps;
        bit                    typed;
        queue_result_t         result;
    } stimulus_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = OP_PUSH;
    logic [FIELD_BITS-1:0] key = '0;
    logic [FIELD_BITS-1:0] payload = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  pop_valid;
    logic [FIELD_BITS-1:0] pop_key;
    logic [FIELD_BITS-1:0] pop_payload;
    logic                  push_dropped;
    logic [COUNT_BITS-1:0] entry_count;

    // Shadow copy of the queue contents
    logic [FIELD_BITS-1:0] shadow_key [DEPTH];
    logic [FIELD_BITS-1:0] shadow_payload [DEPTH];
    int unsigned           shadow_count = 0;

    queue_result_t         awaited_results [$];
    queue_result_t         predicted;
    queue_result_t         oldest;
    bit                    row_typed = 1'b0;
    queue_result_t         row_result = '0;
    stimulus_row_t         directed_rows [ROWS];
    bit                    calm = 1'b0;
    int                    stall_left = 0;
    int unsigned           fail_count = 0;
    int unsigned           cycle_count = 0;

    sorted_priority_queue #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .key          (key),
        .payload      (payload),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pop_valid    (pop_valid),
        .pop_key      (pop_key),
        .pop_payload  (pop_payload),
        .push_dropped (push_dropped),
        .entry_count  (entry_count)
    );

    always #1 clk = ~clk;

    // Apply one item to the shadow list and return the result it should give
    function automatic queue_result_t apply_to_shadow(spq_op_t op, logic [FIELD_BITS-1:0] k_in,
                                                      logic [FIELD_BITS-1:0] p_in);
        queue_result_t         r;
        logic [FIELD_BITS-1:0] k;
        logic [FIELD_BITS-1:0] p;
        int unsigned           pos;
        int unsigned           i;
        r = '0;
        k = k_in & KEY_MASK;
        p = p_in & PAYLOAD_MASK;
        if (op == OP_PUSH) begin
            if (shadow_count >= DEPTH) begin
                r.push_dropped = 1'b1;
            end
            else begin
                // Insert ahead of the first key that is not smaller
                pos = 0;
                while (pos < shadow_count && k > shadow_key[pos])
                    pos++;
                for (i = shadow_count; i > pos; i--) begin
                    shadow_key[i]     = shadow_key[i-1];
                    shadow_payload[i] = shadow_payload[i-1];
                end
                shadow_key[pos]     = k;
                shadow_payload[pos] = p;
                shadow_count++;
            end
        end
        else if (shadow_count > 0) begin
            r.pop_valid   = 1'b1;
            r.pop_key     = shadow_key[0];
            r.pop_payload = shadow_payload[0];
            for (i = 1; i < shadow_count; i++) begin
                shadow_key[i-1]     = shadow_key[i];
                shadow_payload[i-1] = shadow_payload[i];
            end
            shadow_count--;
        end
        r.entry_count = COUNT_BITS'(shadow_count);
        return r;
    endfunction

    task automatic check_field(string name, logic [FIELD_BITS-1:0] want,
                               logic [FIELD_BITS-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    // Check results first, then record the expectation of any item taken at this edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result item arrived with nothing outstanding");
                    fail_count++;
                end
                else begin
                    oldest = awaited_results.pop_front();
                    check_field("pop_valid", FIELD_BITS'(oldest.pop_valid),
                                FIELD_BITS'(pop_valid));
                    check_field("pop_key", oldest.pop_key, pop_key);
                    check_field("pop_payload", oldest.pop_payload, pop_payload);
                    check_field("push_dropped", FIELD_BITS'(oldest.push_dropped),
                                FIELD_BITS'(push_dropped));
                    check_field("entry_count", FIELD_BITS'(oldest.entry_count),
                                FIELD_BITS'(entry_count));
                end
                stall_left = calm ? 0 : $urandom_range(0, 6);
            end
            if (in_valid && !in_stall) begin
                predicted = apply_to_shadow(spq_op_t'(operation), key, payload);
                awaited_results.push_back(row_typed ? row_result : predicted);
            end
        end
    end

    // Hold off the result side for the drawn number of cycles
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Abort a run that hangs
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Drive one item after a random gap and hold it until taken
    task automatic send_item(spq_op_t op, logic [FIELD_BITS-1:0] k, logic [FIELD_BITS-1:0] p,
                             bit typed, queue_result_t result);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        key        <= k;
        payload    <= p;
        row_typed  <= typed;
        row_result <= result;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Pause the sender until every outstanding result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [FIELD_BITS-1:0] draw_key();
        logic [FIELD_BITS-1:0] k;
        case ($urandom_range(0, 9))
            0:       k = '0;
            1:       k = '1;
            2, 3, 4: k = FIELD_BITS'($urandom_range(0, 7));
            5:       k = 32'hFFFF_FFF8 + FIELD_BITS'($urandom_range(0, 7));
            default: k = $urandom;
        endcase
        return k;
    endfunction

    initial begin
        int            push_pct;
        int unsigned   ph;
        int unsigned   n;
        int unsigned   r;
        spq_op_t       op;

        // Directed rows: extremes, equal keys, fill to full and a dropped push
        directed_rows[0] = '{OP_POP,  32'h0, 32'h0, 1, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 5'd0}};
        directed_rows[1] = '{OP_PUSH, 32'h0, 32'h0, 1, 1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 5'd1}};
        directed_rows[2] = '{OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1,
                             '{1'b0, 32'h0, 32'h0, 1'b0, 5'd2}};
        directed_rows[3] = '{OP_POP,  32'h0, 32'h0, 1, 1'b1, '{1'b1, 32'h0, 32'h0, 1'b0, 5'd1}};
        directed_rows[4] = '{OP_POP,  32'h0, 32'h0, 1, 1'b1,
                             '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 5'd0}};
        directed_rows[5] = '{OP_PUSH, 32'h7, 32'h1, 1, 1'b0, '0};
        directed_rows[6] = '{OP_PUSH, 32'h7, 32'h2, 1, 1'b0, '0};
        directed_rows[7] = '{OP_POP,  32'h0, 32'h0, 1, 1'b0, '0};
        directed_rows[8] = '{OP_PUSH, 32'h8000_0000, 32'h5555_5555, 15, 1'b0, '0};
        directed_rows[9] = '{OP_PUSH, 32'h1, 32'hAAAA_AAAA, 1, 1'b1,
                             '{1'b0, 32'h0, 32'h0, 1'b1, 5'd16}};

        // Hold reset low, then release it
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < ROWS; r++) begin
            repeat (directed_rows[r].reps)
                send_item(directed_rows[r].op, directed_rows[r].key, directed_rows[r].payload,
                          directed_rows[r].typed, directed_rows[r].result);
        end
        drain_results();

        // Random phases with varying push share, so the queue swings between empty and full
        for (ph = 0; ph < PHASES; ph++) begin
            calm = (ph % 4 == 3);
            case ($urandom_range(0, 4))
                0:       push_pct = 15;
                1:       push_pct = 85;
                2:       push_pct = 97;
                3:       push_pct = 35;
                default: push_pct = 55;
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
                send_item(op, draw_key(), $urandom, 1'b0, '0);
            end
            if (ph == 0 || $urandom_range(0, 2) == 0)
                drain_results();
        end
        calm = 1'b0;

        // Wait for the last results, then allow the output register to settle
        drain_results();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
